[hdl/cdg_pkg.sv]
package cdg_pkg;

  localparam int CELL_WIDTH  = 6;
  localparam int CELL_HEIGHT = 12;
  localparam int PIX_W       = 4;
  localparam int LINE_BITS   = CELL_WIDTH * PIX_W;
  localparam int SUB_W       = 4;

  localparam logic [2:0] OP_MEM_PRESET    = 3'd0;
  localparam logic [2:0] OP_BORDER_PRESET = 3'd1;
  localparam logic [2:0] OP_TILE_NORMAL   = 3'd2;
  localparam logic [2:0] OP_TILE_XOR      = 3'd3;
  localparam logic [2:0] OP_READ_LINE     = 3'd4;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_SKIPPED  = 2'd1;
  localparam logic [1:0] ST_MASKED   = 2'd2;
  localparam logic [1:0] ST_OFF_SCRN = 2'd3;

  localparam logic [1:0] RK_NONE   = 2'd0;
  localparam logic [1:0] RK_CANVAS = 2'd1;
  localparam logic [1:0] RK_CELL   = 2'd2;

  localparam logic [0:0] REG_CHANNEL_MASK = 1'd0;
  localparam logic [0:0] REG_CORNER_MODE  = 1'd1;

  localparam logic [15:0] CHANNEL_MASK_RST = 16'h0011;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  preset_color;
    logic [3:0]  channel;
    logic [3:0]  back_color;
    logic [3:0]  fore_color;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic [35:0] mask_top;
    logic [35:0] mask_bottom;
    logic [7:0]  read_line;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  refresh_kind;
    logic [4:0]  dirty_row;
    logic [5:0]  dirty_col;
    logic        corner_tile;
    logic        background_refresh;
    logic [23:0] line_pixels;
  } out_word_t;

  // per-pixel lane control, shared by all six lanes
  typedef struct packed {
    logic [3:0] fore;
    logic [3:0] back;
    logic       xor_en;
  } lane_ctl_t;

endpackage

[hdl/cdg_tile_frame_engine.sv]
// Tile frame engine. Holds a 4-bit-per-pixel frame store in one RAM, one
// 24-bit word per six-pixel cell line, and takes one command word at a time.
// A tile write reads and then writes each of its twelve cell lines through
// the single RAM port pair, six pixel lanes forming the new line. Memory
// and border presets sweep every word of the store, one a cycle, the border
// preset writing only words of border cells; a preset skipped as a repeat,
// and a masked or off-screen tile, finish without touching the store. After
// reset the same sweep clears the store to color 0 before the first word is
// accepted; configuration writes are taken at any time. A finished result
// waits in an output register while the next word is accepted.
module cdg_tile_frame_engine #(
  parameter int WIDTH_CELLS  = 50,
  parameter int HEIGHT_CELLS = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdg_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cdg_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int LINES  = HEIGHT_CELLS * cdg_pkg::CELL_HEIGHT;
  localparam int DEPTH  = LINES * WIDTH_CELLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(WIDTH_CELLS);
  localparam int ROW_W  = $clog2(HEIGHT_CELLS);
  localparam int SUB_W_L = cdg_pkg::SUB_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SWEEP = 7'b0000010,
    S_TRD   = 7'b0000100,
    S_TWR   = 7'b0001000,
    S_RD1   = 7'b0010000,
    S_RD2   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [2:0]         op_r, op_nxt;
  logic [3:0]         color_r, color_nxt;
  logic [3:0]         fg_r, fg_nxt;
  logic [3:0]         bg_r, bg_nxt;
  logic [71:0]        mask_r, mask_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [SUB_W_L-1:0] cnt_r, cnt_nxt;
  logic [COL_W-1:0]   col_c_r, col_c_nxt;
  logic [ROW_W-1:0]   crow_c_r, crow_c_nxt;
  logic [3:0]         sub_c_r, sub_c_nxt;
  cdg_pkg::out_word_t res_r, res_nxt;
  logic               emit_r, emit_nxt;
  logic               out_valid_r, out_valid_nxt;
  cdg_pkg::out_word_t out_r, out_nxt;
  logic               pvalid_r, pvalid_nxt;
  logic [3:0]         pheld_r, pheld_nxt;
  logic [15:0]        cmask_r;
  logic               cmode_r;

  cdg_pkg::lane_ctl_t                ctl;
  logic [5:0]                        lane_bits;
  logic [cdg_pkg::LINE_BITS-1:0]     rdata, wdata;
  logic                              we;
  logic                              border_hit;
  logic                              accept;
  logic                              row_ok, col_ok, line_ok;

  // lanes: one per pixel of a cell line, merged into the write word
  for (genvar b = 0; b < cdg_pkg::CELL_WIDTH; b++) begin : g_lane
    cdg_lane u_lane (
      .ctl      (ctl),
      .mask_bit (lane_bits[b]),
      .old_pix  (rdata[4*b +: 4]),
      .new_pix  (wdata[4*b +: 4])
    );
  end

  cdg_ram #(.WIDTH(cdg_pkg::LINE_BITS), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr_r),
    .wdata (wdata),
    .raddr (addr_r),
    .rdata (rdata)
  );

  always_comb begin
    if (state_r == S_SWEEP) begin
      ctl.fore   = color_r;
      ctl.back   = color_r;
      ctl.xor_en = 1'b0;
      lane_bits  = 6'd0;
    end else begin
      ctl.fore   = fg_r;
      ctl.back   = bg_r;
      ctl.xor_en = (op_r == cdg_pkg::OP_TILE_XOR);
      lane_bits  = mask_r[5:0];
    end
  end

  assign border_hit = (crow_c_r == '0) || (crow_c_r == ROW_W'(HEIGHT_CELLS - 1)) ||
                      (col_c_r == '0) || (col_c_r == COL_W'(WIDTH_CELLS - 1));
  assign we = ((state_r == S_SWEEP) && ((op_r != cdg_pkg::OP_BORDER_PRESET) || border_hit))
              || (state_r == S_TWR);

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign row_ok  = 32'(in_data.cell_row) < HEIGHT_CELLS;
  assign col_ok  = 32'(in_data.cell_col) < WIDTH_CELLS;
  assign line_ok = 32'(in_data.read_line) < LINES;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    color_nxt     = color_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    mask_nxt      = mask_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    col_c_nxt     = col_c_r;
    crow_c_nxt    = crow_c_r;
    sub_c_nxt     = sub_c_r;
    res_nxt       = res_r;
    emit_nxt      = emit_r;
    pvalid_nxt    = pvalid_r;
    pheld_nxt     = pheld_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_data.opcode;
          color_nxt  = in_data.preset_color;
          fg_nxt     = in_data.fore_color;
          bg_nxt     = in_data.back_color;
          mask_nxt   = {in_data.mask_bottom, in_data.mask_top};
          cnt_nxt    = '0;
          col_c_nxt  = '0;
          crow_c_nxt = '0;
          sub_c_nxt  = '0;
          emit_nxt   = 1'b1;
          res_nxt    = '0;
          state_nxt  = S_FIN;
          unique case (in_data.opcode)
            cdg_pkg::OP_MEM_PRESET: begin
              if (pvalid_r && pheld_r == in_data.preset_color) begin
                res_nxt.status = cdg_pkg::ST_SKIPPED;
              end else begin
                addr_nxt                   = '0;
                pvalid_nxt                 = 1'b1;
                pheld_nxt                  = in_data.preset_color;
                res_nxt.refresh_kind       = cdg_pkg::RK_CANVAS;
                res_nxt.background_refresh = cmode_r;
                state_nxt                  = S_SWEEP;
              end
            end
            cdg_pkg::OP_BORDER_PRESET: begin
              addr_nxt             = '0;
              pvalid_nxt           = 1'b0;
              res_nxt.refresh_kind = cdg_pkg::RK_CANVAS;
              state_nxt            = S_SWEEP;
            end
            cdg_pkg::OP_TILE_NORMAL, cdg_pkg::OP_TILE_XOR: begin
              if (!cmask_r[in_data.channel]) begin
                res_nxt.status = cdg_pkg::ST_MASKED;
              end else if (!row_ok || !col_ok) begin
                res_nxt.status = cdg_pkg::ST_OFF_SCRN;
              end else begin
                addr_nxt = ADDR_W'(in_data.cell_row) *
                           ADDR_W'(cdg_pkg::CELL_HEIGHT * WIDTH_CELLS) +
                           ADDR_W'(in_data.cell_col);
                pvalid_nxt           = 1'b0;
                res_nxt.refresh_kind = cdg_pkg::RK_CELL;
                res_nxt.dirty_row    = in_data.cell_row[4:0];
                res_nxt.dirty_col    = in_data.cell_col;
                res_nxt.corner_tile  =
                  ((32'(in_data.cell_row) == 1) || (32'(in_data.cell_row) == HEIGHT_CELLS - 2))
                  && ((32'(in_data.cell_col) == 1) || (32'(in_data.cell_col) == WIDTH_CELLS - 2));
                state_nxt = S_TRD;
              end
            end
            cdg_pkg::OP_READ_LINE: begin
              if (!line_ok || !col_ok) begin
                res_nxt.status = cdg_pkg::ST_OFF_SCRN;
              end else begin
                addr_nxt  = ADDR_W'(in_data.read_line) * ADDR_W'(WIDTH_CELLS) +
                            ADDR_W'(in_data.cell_col);
                state_nxt = S_RD1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SWEEP: begin
        addr_nxt = addr_r + 1'b1;
        if (col_c_r == COL_W'(WIDTH_CELLS - 1)) begin
          col_c_nxt = '0;
          if (sub_c_r == 4'(cdg_pkg::CELL_HEIGHT - 1)) begin
            sub_c_nxt  = '0;
            crow_c_nxt = crow_c_r + 1'b1;
          end else begin
            sub_c_nxt = sub_c_r + 1'b1;
          end
        end else begin
          col_c_nxt = col_c_r + 1'b1;
        end
        if (addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_TRD: begin
        state_nxt = S_TWR;
      end
      S_TWR: begin
        addr_nxt = addr_r + ADDR_W'(WIDTH_CELLS);
        mask_nxt = {6'd0, mask_r[71:6]};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == SUB_W_L'(cdg_pkg::CELL_HEIGHT - 1)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_TRD;
        end
      end
      S_RD1: begin
        state_nxt = S_RD2;
      end
      S_RD2: begin
        res_nxt.line_pixels = rdata;
        state_nxt           = S_FIN;
      end
      S_FIN: begin
        if (!emit_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      op_r        <= cdg_pkg::OP_MEM_PRESET;
      color_r     <= 4'd0;
      addr_r      <= '0;
      cnt_r       <= '0;
      col_c_r     <= '0;
      crow_c_r    <= '0;
      sub_c_r     <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pvalid_r    <= 1'b0;
      pheld_r     <= 4'd0;
      cmask_r     <= cdg_pkg::CHANNEL_MASK_RST;
      cmode_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      color_r     <= color_nxt;
      addr_r      <= addr_nxt;
      cnt_r       <= cnt_nxt;
      col_c_r     <= col_c_nxt;
      crow_c_r    <= crow_c_nxt;
      sub_c_r     <= sub_c_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      pvalid_r    <= pvalid_nxt;
      pheld_r     <= pheld_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          cdg_pkg::REG_CHANNEL_MASK: cmask_r <= cfg_wdata;
          cdg_pkg::REG_CORNER_MODE:  cmode_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    fg_r   <= fg_nxt;
    bg_r   <= bg_nxt;
    mask_r <= mask_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule

[hdl/cdg_ram.sv]
module cdg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 10800
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/cdg_lane.sv]
module cdg_lane (
  input  cdg_pkg::lane_ctl_t ctl,
  input  logic               mask_bit,
  input  logic [3:0]         old_pix,
  output logic [3:0]         new_pix
);

  logic [3:0] pix;

  assign pix     = mask_bit ? ctl.fore : ctl.back;
  assign new_pix = ctl.xor_en ? (old_pix ^ pix) : pix;

endmodule
